// ----- rtl/ets_pkg.sv -----
// ----------------------------------------------------------------------------
// ets_pkg: shared types and constants for the epoch task scheduler
// Payload words, task mode codes and the front-to-back command word.
// ----------------------------------------------------------------------------
package ets_pkg;

    localparam int NUM_TASKS_DEF = 16;
    localparam int SLOT_W = 4;

    localparam logic [2:0] MODE_DEAD     = 3'd0;
    localparam logic [2:0] MODE_RUNNABLE = 3'd1;
    localparam logic [2:0] MODE_WAITING  = 3'd2;
    localparam logic [2:0] MODE_SLEEPING = 3'd3;
    localparam logic [2:0] MODE_STOPPING = 3'd4;

    localparam logic FUNC_SCHED = 1'b0;
    localparam logic FUNC_LOAD  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] now_ms;
        logic [3:0]  slot;
        logic        slot_valid;
        logic [2:0]  task_state_in;
        logic [6:0]  priority_in;
        logic [7:0]  ticks_in;
        logic [31:0] wake_time_in;
        logic        overflow_in;
    } in_word_t;

    typedef struct packed {
        logic       found;
        logic [3:0] next_slot;
        logic       reaper_wake;
        logic       recalculated;
    } out_word_t;

    // command handed from front to back; in_range set when load slot fits the table
    typedef struct packed {
        in_word_t word;
        logic     in_range;
    } cmd_t;

endpackage

// ----- rtl/epoch_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// epoch_task_scheduler: epoch-based counter priority scheduler
// Task slot table with load and schedule words.
// ----------------------------------------------------------------------------
// A load word passes through the back end's done state. A schedule word scans one slot
// per cycle, then runs a tick refill pass and a second scan when the first scan
// finds every runnable task at zero ticks. The back end is a single-slot
// scan sequencer over the task table. A two-entry queue lets the front take
// words while the back end scans or while a result waits to be taken.
module epoch_task_scheduler #(
    parameter int NUM_TASKS = ets_pkg::NUM_TASKS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ets_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ets_pkg::out_word_t out_data
);

    logic          cmd_valid, cmd_ready;
    ets_pkg::cmd_t cmd;

    ets_front #(.NUM_TASKS(NUM_TASKS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    ets_back #(.NUM_TASKS(NUM_TASKS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

endmodule

// ----- rtl/ets_front.sv -----
// ----------------------------------------------------------------------------
// ets_front: input stage and command queue
// Accepts input words, classifies loads by slot range, queues two commands.
// ----------------------------------------------------------------------------
module ets_front #(
    parameter int NUM_TASKS = ets_pkg::NUM_TASKS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ets_pkg::in_word_t in_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output ets_pkg::cmd_t     cmd
);

    ets_pkg::cmd_t q_reg [2];
    logic [1:0]    cnt_reg, cnt_next;
    logic          rd_reg, rd_next;
    logic          wr_reg, wr_next;
    ets_pkg::cmd_t new_cmd;
    logic          push, pop;

    always_comb
    begin
        new_cmd.word     = in_data;
        new_cmd.in_range = (int'(in_data.slot) < NUM_TASKS);
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
        rd_next  = rd_reg ^ pop;
        wr_next  = wr_reg ^ push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= new_cmd;
    end

endmodule

// ----- rtl/ets_back.sv -----
// ----------------------------------------------------------------------------
// ets_back: task table and scan sequencer
// Walks the slots one per cycle: overflow, wake, best pick, then recalc when all runnable are at zero ticks.
// ----------------------------------------------------------------------------
module ets_back #(
    parameter int NUM_TASKS = ets_pkg::NUM_TASKS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  ets_pkg::cmd_t      cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output ets_pkg::out_word_t out_data
);

    localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    typedef enum logic [1:0] { S_IDLE, S_SCAN, S_RECALC, S_DONE } state_t;

    state_t      state_reg;
    logic [IW-1:0] idx_reg;
    logic [NUM_TASKS-1:0] present_reg;
    logic [2:0]  mode_reg   [NUM_TASKS];
    logic [7:0]  ticks_reg  [NUM_TASKS];
    logic [6:0]  prio_reg   [NUM_TASKS];
    logic [31:0] wake_reg   [NUM_TASKS];
    logic        ovf_reg    [NUM_TASKS];
    logic [31:0] now_reg;
    logic        have_reg;
    logic [7:0]  top_reg;
    logic [IW-1:0] best_reg;
    logic        reaper_reg, recalc_reg;
    ets_pkg::out_word_t res_reg;
    logic        res_valid_reg;

    logic [2:0]  m0, m1, m2;
    logic        ovf_hit;
    logic        last;
    logic        better;
    logic [IW-1:0] ld_idx;

    assign last      = (idx_reg == IW'(NUM_TASKS - 1));
    assign cmd_ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;
    assign ld_idx    = IW'(cmd.word.slot);

    // per-slot mode update for the slot under scan
    always_comb
    begin
        m0 = mode_reg[idx_reg];
        ovf_hit = present_reg[idx_reg] && (m0 == ets_pkg::MODE_RUNNABLE)
                  && ovf_reg[idx_reg];
        m1 = ovf_hit ? ets_pkg::MODE_STOPPING : m0;
        m2 = ((m1 == ets_pkg::MODE_SLEEPING) && (now_reg >= wake_reg[idx_reg]))
             ? ets_pkg::MODE_RUNNABLE : m1;
        better = present_reg[idx_reg] && (m2 == ets_pkg::MODE_RUNNABLE)
                 && (!have_reg || (ticks_reg[idx_reg] > top_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            present_reg   <= '0;
            res_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (res_valid_reg && out_ready)
                res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid && cmd_ready)
                    begin
                        if (cmd.word.func == ets_pkg::FUNC_LOAD)
                        begin
                            if (cmd.in_range)
                                present_reg[ld_idx] <= cmd.word.slot_valid;
                            state_reg <= S_DONE;
                            have_reg  <= 1'b0;
                            reaper_reg <= 1'b0;
                            recalc_reg <= 1'b0;
                        end
                        else
                        begin
                            state_reg  <= S_SCAN;
                            idx_reg    <= '0;
                            have_reg   <= 1'b0;
                            top_reg    <= '0;
                            best_reg   <= '0;
                            reaper_reg <= 1'b0;
                            recalc_reg <= 1'b0;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (ovf_hit)
                        reaper_reg <= 1'b1;
                    if (better)
                    begin
                        have_reg <= 1'b1;
                        top_reg  <= ticks_reg[idx_reg];
                        best_reg <= idx_reg;
                    end
                    idx_reg <= last ? '0 : idx_reg + 1'b1;
                    if (last)
                    begin
                        // all runnable at zero ticks: refill once
                        if (!recalc_reg && (have_reg || better)
                            && (better ? ticks_reg[idx_reg] == 8'd0 : top_reg == 8'd0))
                        begin
                            state_reg <= S_RECALC;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                end
                S_RECALC:
                begin
                    idx_reg <= last ? '0 : idx_reg + 1'b1;
                    if (last)
                    begin
                        recalc_reg <= 1'b1;
                        have_reg   <= 1'b0;
                        top_reg    <= '0;
                        best_reg   <= '0;
                        state_reg  <= S_SCAN;
                    end
                end
                S_DONE:
                begin
                    res_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid && cmd_ready
            && cmd.word.func == ets_pkg::FUNC_LOAD && cmd.in_range)
        begin
            mode_reg[ld_idx]  <= cmd.word.task_state_in;
            ticks_reg[ld_idx] <= cmd.word.ticks_in;
            prio_reg[ld_idx]  <= cmd.word.priority_in;
            wake_reg[ld_idx]  <= cmd.word.wake_time_in;
            ovf_reg[ld_idx]   <= cmd.word.overflow_in;
        end
        if (state_reg == S_SCAN && present_reg[idx_reg])
            mode_reg[idx_reg] <= m2;
        if (state_reg == S_RECALC && present_reg[idx_reg])
            ticks_reg[idx_reg] <= {1'b0, ticks_reg[idx_reg][7:1]}
                                  + {1'b0, prio_reg[idx_reg]};
        if (state_reg == S_IDLE && cmd_valid && cmd_ready)
            now_reg <= cmd.word.now_ms;
        if (state_reg == S_DONE)
        begin
            res_reg.found        <= have_reg;
            res_reg.next_slot    <= have_reg ? 4'(best_reg) : 4'd0;
            res_reg.reaper_wake  <= reaper_reg;
            res_reg.recalculated <= recalc_reg;
        end
    end

endmodule

// ----- rtl/ets_checker.sv -----
// ----------------------------------------------------------------------------
// ets_checker: port-level checks for the scheduler
// Result word consistency and output handshake.
// ----------------------------------------------------------------------------
module ets_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input ets_pkg::out_word_t out_data
);

    // idle result reports slot zero
    a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.found) |-> (out_data.next_slot == 4'd0))
        else $error("next_slot nonzero without found");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(out_data))
        else $error("result word has unknown bits");

    a_in_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(in_ready))
        else $error("in_ready unknown");

    a_accept_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(rst_n))
        else $error("result out of reset");

endmodule

bind epoch_task_scheduler ets_checker u_ets_checker (
    .clk(clk), .rst_n(rst_n),
    .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ----- verif/epoch_task_scheduler_tb.sv -----
// ----------------------------------------------------------------------------
// epoch_task_scheduler_tb: self-checking bench for the epoch task scheduler
// Loads task slots and issues schedule requests; a behavioral copy of the
// slot table predicts every result word, which is compared in arrival order.
// ----------------------------------------------------------------------------
module epoch_task_scheduler_tb;

    localparam int NSLOT = 16;

    // mode codes outside the defined set
    localparam logic [2:0] MODE_ODD_LO = 3'd5;
    localparam logic [2:0] MODE_ODD_HI = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    ets_pkg::in_word_t  in_data;
    logic               out_valid;
    logic               out_ready;
    ets_pkg::out_word_t out_data;

    // predictor copy of the slot table
    logic        tbl_present [NSLOT];
    logic [2:0]  tbl_mode [NSLOT];
    logic [7:0]  tbl_ticks [NSLOT];
    logic [6:0]  tbl_prio [NSLOT];
    logic [31:0] tbl_wake [NSLOT];
    logic        tbl_ovf [NSLOT];

    ets_pkg::out_word_t pending_q[$];
    int        err_cnt;
    bit        idle_en;
    bit        sink_busy;

    epoch_task_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // one pass over the table; returns best ticks or -1 when none runnable
    function automatic int scan_table(input logic [31:0] now, output logic [3:0] pick,
                                      inout logic reaper);
        int top;
        top = -1;
        pick = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (tbl_present[i])
            begin
                if (tbl_mode[i] == ets_pkg::MODE_RUNNABLE && tbl_ovf[i])
                begin
                    tbl_mode[i] = ets_pkg::MODE_STOPPING;
                    reaper = 1'b1;
                end
                if (tbl_mode[i] == ets_pkg::MODE_SLEEPING && now >= tbl_wake[i])
                    tbl_mode[i] = ets_pkg::MODE_RUNNABLE;
                if (tbl_mode[i] == ets_pkg::MODE_RUNNABLE && int'(tbl_ticks[i]) > top)
                begin
                    top = int'(tbl_ticks[i]);
                    pick = i[3:0];
                end
            end
        end
        return top;
    endfunction

    function automatic ets_pkg::out_word_t predict_sched(input ets_pkg::in_word_t w);
        ets_pkg::out_word_t r;
        logic [3:0] pick;
        logic reaper;
        int top;
        r = '0;
        reaper = 1'b0;
        if (w.func == ets_pkg::FUNC_LOAD)
        begin
            tbl_present[w.slot] = w.slot_valid;
            tbl_mode[w.slot]    = w.task_state_in;
            tbl_prio[w.slot]    = w.priority_in;
            tbl_ticks[w.slot]   = w.ticks_in;
            tbl_wake[w.slot]    = w.wake_time_in;
            tbl_ovf[w.slot]     = w.overflow_in;
            return r;
        end
        top = scan_table(w.now_ms, pick, reaper);
        if (top == 0)
        begin
            r.recalculated = 1'b1;
            for (int i = 0; i < NSLOT; i++)
                if (tbl_present[i])
                    tbl_ticks[i] = (tbl_ticks[i] >> 1) + 8'(tbl_prio[i]);
            top = scan_table(w.now_ms, pick, reaper);
        end
        r.found       = (top >= 0);
        r.next_slot   = (top >= 0) ? pick : 4'd0;
        r.reaper_wake = reaper;
        return r;
    endfunction

    task automatic send_word(input ets_pkg::in_word_t w);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        pending_q.push_back(predict_sched(w));
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic load_slot(input int s, input logic v, input logic [2:0] m,
                             input logic [6:0] p, input logic [7:0] t,
                             input logic [31:0] wk, input logic o);
        ets_pkg::in_word_t w;
        w = '0;
        w.func = ets_pkg::FUNC_LOAD;
        w.slot = s[3:0];
        w.slot_valid = v;
        w.task_state_in = m;
        w.priority_in = p;
        w.ticks_in = t;
        w.wake_time_in = wk;
        w.overflow_in = o;
        w.now_ms = $urandom;
        send_word(w);
    endtask

    task automatic schedule_at(input logic [31:0] now);
        ets_pkg::in_word_t w;
        w = '0;
        w.func = ets_pkg::FUNC_SCHED;
        w.now_ms = now;
        w.slot = 4'($urandom);
        w.ticks_in = 8'($urandom);
        w.wake_time_in = $urandom;
        send_word(w);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0) @(posedge clk);
    endtask

    // result checker and random back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_q.size() == 0)
                begin
                    $error("unexpected result word %h", out_data);
                    err_cnt++;
                end
                else
                begin
                    ets_pkg::out_word_t e;
                    e = pending_q.pop_front();
                    if (out_data.found !== e.found)
                    begin
                        $error("found exp %0d got %0d", e.found, out_data.found);
                        err_cnt++;
                    end
                    if (out_data.next_slot !== e.next_slot)
                    begin
                        $error("next_slot exp %0d got %0d", e.next_slot, out_data.next_slot);
                        err_cnt++;
                    end
                    if (out_data.reaper_wake !== e.reaper_wake)
                    begin
                        $error("reaper_wake exp %0d got %0d", e.reaper_wake,
                               out_data.reaper_wake);
                        err_cnt++;
                    end
                    if (out_data.recalculated !== e.recalculated)
                    begin
                        $error("recalculated exp %0d got %0d", e.recalculated,
                               out_data.recalculated);
                        err_cnt++;
                    end
                end
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_en && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // extremes, load corner cases, idle and empty table
    task automatic test_directed();
        schedule_at(32'h0);
        load_slot(0, 1'b1, ets_pkg::MODE_RUNNABLE, 7'd127, 8'd255, 32'hFFFF_FFFF, 1'b0);
        load_slot(15, 1'b1, ets_pkg::MODE_RUNNABLE, 7'd1, 8'd255, 32'h0, 1'b0);
        schedule_at(32'hFFFF_FFFF);
        load_slot(0, 1'b0, ets_pkg::MODE_RUNNABLE, 7'd5, 8'd0, 32'h0, 1'b1);
        schedule_at(32'd10);
        // zero ticks everywhere forces recalculation
        load_slot(15, 1'b1, ets_pkg::MODE_RUNNABLE, 7'd3, 8'd0, 32'h0, 1'b0);
        load_slot(7, 1'b1, ets_pkg::MODE_RUNNABLE, 7'd9, 8'd0, 32'h0, 1'b0);
        schedule_at(32'd20);
        // overflowed runnable goes stopping
        load_slot(3, 1'b1, ets_pkg::MODE_RUNNABLE, 7'd2, 8'd200, 32'h0, 1'b1);
        schedule_at(32'd30);
        // overflowed sleeper is recalculated while asleep, then wakes runnable
        load_slot(7, 1'b1, ets_pkg::MODE_SLEEPING, 7'd4, 8'd0, 32'd100, 1'b1);
        load_slot(15, 1'b1, ets_pkg::MODE_RUNNABLE, 7'd0, 8'd0, 32'h0, 1'b0);
        schedule_at(32'd99);
        schedule_at(32'd100);
        // zero priority: stays zero after recalculation
        load_slot(7, 1'b0, ets_pkg::MODE_DEAD, 7'd0, 8'd0, 32'h0, 1'b0);
        schedule_at(32'd200);
        // unknown modes and waiting/dead
        load_slot(1, 1'b1, MODE_ODD_HI, 7'd1, 8'd50, 32'h0, 1'b0);
        load_slot(2, 1'b1, MODE_ODD_LO, 7'd1, 8'd50, 32'h0, 1'b1);
        load_slot(4, 1'b1, ets_pkg::MODE_WAITING, 7'd1, 8'd50, 32'h0, 1'b0);
        schedule_at(32'd300);
        drain_results();
    endtask

    task automatic test_random(input int n);
        int kind;
        for (int k = 0; k < n; k++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 5)
                load_slot($urandom_range(0, 15), $urandom_range(0, 5) != 0,
                          ($urandom_range(0, 9) == 0) ? 3'($urandom) :
                          3'($urandom_range(1, 4)),
                          ($urandom_range(0, 9) == 0) ? 7'($urandom) :
                          7'($urandom_range(0, 3)),
                          ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom),
                          ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 2000)),
                          $urandom_range(0, 7) == 0);
            else if (kind < 9)
                schedule_at(32'($urandom_range(0, 2000)));
            else
                schedule_at($urandom);
            if (k == n / 2)
                drain_results();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        err_cnt   = 0;
        idle_en   = 1'b1;
        for (int i = 0; i < NSLOT; i++)
        begin
            tbl_present[i] = 1'b0;
            tbl_mode[i] = '0;
            tbl_ticks[i] = '0;
            tbl_prio[i] = '0;
            tbl_wake[i] = '0;
            tbl_ovf[i] = 1'b0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(550);
        idle_en = 1'b0;
        test_random(150);
        drain_results();
        repeat (200) @(posedge clk);
        if (err_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
